// ===== sv/gcd_lcm_pkg.sv =====
package gcd_lcm_pkg;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture operands
		logic gcd_step;  // one binary-gcd reduction
		logic gcd_fin;   // latch gcd, set up divider
		logic div_step;  // one restoring-division bit
		logic mul_init;  // seed multiplier with the final quotient
		logic mul_step;  // one shift-add multiply bit
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic gcd_zero;  // at least one working operand has reached zero
	} status_t;

endpackage

// ===== sv/gcd_lcm_unit_core.sv =====
// GCD/LCM unit. Pulse start with both operands while busy is low; the
// operands are sampled on that edge. Only the low OPERAND_WIDTH bits of each
// operand are used. The gcd is found by a binary (shift/subtract) loop whose
// length depends on the operands; the lcm is then formed as (first/gcd)*second
// by a one-bit-per-cycle restoring divider and a one-bit-per-cycle shift-add
// multiplier. done is a one-cycle strobe and gcd_value/lcm_value are valid
// only in that cycle; the receiver cannot stall, so capture them then. A zero
// operand gives gcd(0,b)=b and lcm 0. A new request may be issued in the same
// cycle that done is high.
module gcd_lcm_unit_core #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] first_value,
	input  logic [15:0] second_value,
	output logic        done,
	output logic [15:0] gcd_value,
	output logic [31:0] lcm_value
);

	gcd_lcm_pkg::cmd_t    cmd;
	gcd_lcm_pkg::status_t status;

	gcd_lcm_dp #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_dp (
		.clk         (clk),
		.first_value (first_value),
		.second_value(second_value),
		.cmd         (cmd),
		.status      (status),
		.gcd_value   (gcd_value),
		.lcm_value   (lcm_value)
	);

	gcd_lcm_ctrl #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not make the unit busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_lcm_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		done && (lcm_value != 32'd0) |-> gcd_value != 16'd0)
		else $error("nonzero lcm with zero gcd");
`endif

endmodule

// ===== sv/gcd_lcm_dp.sv =====
module gcd_lcm_dp #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                   clk,
	input  logic [15:0]            first_value,
	input  logic [15:0]            second_value,
	input  gcd_lcm_pkg::cmd_t      cmd,
	output gcd_lcm_pkg::status_t   status,
	output logic [15:0]            gcd_value,
	output logic [31:0]            lcm_value
);

	localparam int W  = OPERAND_WIDTH;
	localparam int KW = $clog2(W);

	logic [W-1:0]   a_q, b_q;
	logic [W-1:0]   x_q, y_q;
	logic [KW-1:0]  k_q;
	logic [W-1:0]   g_q;
	logic [W-1:0]   rem_q, quo_q;
	logic [2*W-1:0] prod_q;

	logic [W-1:0]   gcd_base;
	logic [W:0]     div_shift;
	logic           div_fits;
	logic [W-1:0]   rem_d, quo_d;
	logic [W:0]     mul_sum;

	assign gcd_base  = (x_q == '0) ? y_q : x_q;

	// restoring division: bring down next dividend bit, subtract if it fits
	assign div_shift = {rem_q, quo_q[W-1]};
	assign div_fits  = div_shift >= {1'b0, g_q};
	always_comb begin
		if (div_fits) begin
			rem_d = W'(div_shift - {1'b0, g_q});
			quo_d = {quo_q[W-2:0], 1'b1};
		end else begin
			rem_d = div_shift[W-1:0];
			quo_d = {quo_q[W-2:0], 1'b0};
		end
	end

	assign mul_sum = {1'b0, prod_q[2*W-1:W]} + (prod_q[0] ? {1'b0, b_q} : {(W+1){1'b0}});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= W'(first_value);
			b_q <= W'(second_value);
			x_q <= W'(first_value);
			y_q <= W'(second_value);
			k_q <= '0;
		end
		if (cmd.gcd_step) begin
			if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q >= y_q) begin
				x_q <= x_q - y_q;
			end else begin
				y_q <= y_q - x_q;
			end
		end
		if (cmd.gcd_fin) begin
			g_q   <= gcd_base << k_q;
			rem_q <= '0;
			quo_q <= a_q;
		end
		if (cmd.div_step) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
		if (cmd.mul_init) begin
			prod_q <= {{W{1'b0}}, quo_d};
		end
		if (cmd.mul_step) begin
			prod_q <= {mul_sum, prod_q[W-1:1]};
		end
	end

	assign status.gcd_zero = (x_q == '0) || (y_q == '0);
	assign gcd_value       = 16'(g_q);
	assign lcm_value       = 32'(prod_q);

endmodule

// ===== sv/gcd_lcm_ctrl.sv =====
module gcd_lcm_ctrl #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  gcd_lcm_pkg::status_t status,
	output gcd_lcm_pkg::cmd_t    cmd,
	output logic                 busy,
	output logic                 done
);

	localparam int CW = $clog2(OPERAND_WIDTH);
	localparam logic [CW-1:0] CNT_LAST = CW'(OPERAND_WIDTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIV,
		ST_MUL
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic          cnt_last;

	assign cnt_last = cnt_q == CNT_LAST;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.load = start;
			ST_GCD: begin
				if (status.gcd_zero) begin
					cmd.gcd_fin = 1'b1;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cmd.mul_init = cnt_last;
			end
			ST_MUL: cmd.mul_step = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			// strobe on the edge that retires the last multiply bit
			done_q <= (state_q == ST_MUL) && cnt_last;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_GCD;
					end
				end
				ST_GCD: begin
					if (status.gcd_zero) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MUL: begin
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = state_q != ST_IDLE;
	assign done = done_q;

endmodule

// ===== tb/gcd_lcm_checker.sv =====
`timescale 1ns / 1ps

module gcd_lcm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [15:0] first_value,
	input  logic [15:0] second_value,
	input  logic        done,
	input  logic [15:0] gcd_value,
	input  logic [31:0] lcm_value,
	output int          mismatch_count,
	output int          outstanding
);

	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [15:0] first_value;
		logic [15:0] second_value;
		logic [15:0] gcd_value;
		logic [31:0] lcm_value;
	} gcd_lcm_t;

	gcd_lcm_t expected_q[$];
	int       errors = 0;

	// Euclid for the divisor, then (a / gcd) * b; any zero operand gives lcm 0
	function automatic gcd_lcm_t compute_gcd_lcm(logic [15:0] a, logic [15:0] b);
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] r;
		gcd_lcm_t    res;
		x = 32'(a);
		y = 32'(b);
		while (y != 32'd0) begin
			r = x % y;
			x = y;
			y = r;
		end
		res.first_value  = a;
		res.second_value = b;
		res.gcd_value    = x[15:0];
		if (a == 16'd0 || b == 16'd0)
			res.lcm_value = 32'd0;
		else
			res.lcm_value = (32'(a) / x) * 32'(b);
		return res;
	endfunction

	task automatic report_mismatch(string what, gcd_lcm_t exp_res);
		errors++;
		if (errors <= REPORT_LIMIT)
			$display("%0t: %s for a=%0d b=%0d: expected gcd=%0d lcm=%0d, got gcd=%0d lcm=%0d",
				$time, what, exp_res.first_value, exp_res.second_value,
				exp_res.gcd_value, exp_res.lcm_value, gcd_value, lcm_value);
	endtask

	always @(posedge clk) begin
		gcd_lcm_t exp_res;
		if (arst_n) begin
			// a result leaving on this edge never belongs to a request taken on it
			if (done === 1'b1) begin
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: result with no request pending: gcd=%0d lcm=%0d",
							$time, gcd_value, lcm_value);
				end else begin
					exp_res = expected_q.pop_front();
					if (gcd_value !== exp_res.gcd_value || lcm_value !== exp_res.lcm_value)
						report_mismatch("mismatch", exp_res);
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				expected_q.push_back(compute_gcd_lcm(first_value, second_value));
		end
		mismatch_count <= errors;
		outstanding    <= expected_q.size();
	end

endmodule

// ===== tb/gcd_lcm_unit_core_tb.sv =====
`timescale 1ns / 1ps

module gcd_lcm_unit_core_tb;

	localparam int RANDOM_ITEMS = 500;
	localparam int DRAIN_CYCLES = 120;
	localparam int CYCLE_LIMIT  = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [15:0] first_value = 16'd0;
	logic [15:0] second_value = 16'd0;
	logic        done;
	logic [15:0] gcd_value;
	logic [31:0] lcm_value;

	int mismatch_count;
	int outstanding;
	int cycle_count = 0;
	bit idle_enable = 1'b1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	gcd_lcm_unit_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.first_value  (first_value),
		.second_value (second_value),
		.done         (done),
		.gcd_value    (gcd_value),
		.lcm_value    (lcm_value)
	);

	gcd_lcm_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.first_value    (first_value),
		.second_value   (second_value),
		.done           (done),
		.gcd_value      (gcd_value),
		.lcm_value      (lcm_value),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	// called at a falling edge; returns at the falling edge after the request is taken
	task automatic issue_request(logic [15:0] a, logic [15:0] b);
		int gap;
		gap = idle_enable ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start        <= 1'b1;
		first_value  <= a;
		second_value <= b;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic issue_random_request();
		logic [15:0] a;
		logic [15:0] b;
		int          g;
		int          kind;
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			a = 16'($urandom);
			b = 16'($urandom);
		end else if (kind < 55) begin
			// shared factor so the gcd is not trivially 1
			g = $urandom_range(1, 255);
			a = 16'(g * $urandom_range(1, 65535 / g));
			b = 16'(g * $urandom_range(1, 65535 / g));
		end else if (kind < 65) begin
			a = 16'($urandom_range(1, 255) << $urandom_range(0, 8));
			b = 16'($urandom_range(1, 255) << $urandom_range(0, 8));
		end else if (kind < 72) begin
			a = 16'($urandom);
			b = a;
		end else if (kind < 78) begin
			a = 16'd1;
			b = 16'($urandom);
			if ($urandom_range(0, 1)) {a, b} = {b, a};
		end else if (kind < 82) begin
			a = 16'd0;
			b = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
			if ($urandom_range(0, 1)) {a, b} = {b, a};
		end else if (kind < 90) begin
			a = 16'($urandom_range(1, 64));
			b = 16'($urandom_range(1, 64));
		end else begin
			// one operand divides the other
			g = $urandom_range(1, 255);
			b = 16'($urandom_range(1, 65535 / g));
			a = 16'(b * g);
			if ($urandom_range(0, 1)) {a, b} = {b, a};
		end
		issue_request(a, b);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		issue_request(16'd1, 16'd1);
		issue_request(16'd1, 16'd65535);
		issue_request(16'd65535, 16'd1);
		issue_request(16'd65535, 16'd65535);
		issue_request(16'd65535, 16'd65534);
		issue_request(16'd0, 16'd5);
		issue_request(16'd7, 16'd0);
		issue_request(16'd0, 16'd0);
		issue_request(16'd0, 16'd65535);
		issue_request(16'd12, 16'd18);
		issue_request(16'd65521, 16'd65519);  // two primes
		issue_request(16'd65521, 16'd65521);
		issue_request(16'd32768, 16'd65535);
		issue_request(16'd32768, 16'd49152);
		issue_request(16'd2, 16'd65534);
		issue_request(16'd4096, 16'd1024);
		issue_request(16'd65535, 16'd257);
		issue_request(16'd40000, 16'd60000);
		issue_request(16'hAAAA, 16'h5555);
		issue_request(16'd65521, 16'd65535);
		wait_all_results();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 50 == 0)
				idle_enable = ($urandom_range(0, 3) != 0);
			if (i % 125 == 124)
				wait_all_results();
			issue_random_request();
		end

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycle_count);
		$display("Verification failed");
		$finish;
	end

endmodule
